[rtl/core/mandelbrot_escape_time_unit_assert.svh]
// Assertion macros used by the checker file of this block.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MET_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mandelbrot escape time unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MET_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mandelbrot escape time unit: next-cycle check failed");

`endif

[rtl/core/met_pkg.sv]
`default_nettype none

package met_pkg;

    localparam int COORD_W       = 32;
    localparam int INDEX_W       = 9;
    localparam int ITER_W        = 16;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 16;
    localparam int OUT_TUSER_W   = 1;

    // Grid size is a power of two, so the scale step is an arithmetic shift.
    localparam int GRID_SIZE     = 512;
    localparam int GRID_SHIFT    = $clog2(GRID_SIZE);
    localparam int FRACTION_BITS = 28;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_REAL       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_IMAG       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_REAL       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_IMAG       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITERATIONS = 3'd4;

    localparam logic signed [COORD_W-1:0] RESET_MIN_REAL = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] RESET_MIN_IMAG = -32'sd322122547;
    localparam logic signed [COORD_W-1:0] RESET_MAX_REAL = 32'sd268435456;
    localparam logic signed [COORD_W-1:0] RESET_MAX_IMAG = 32'sd483183821;
    localparam logic [ITER_W-1:0]         RESET_MAX_ITER = 16'd2000;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_real;
        logic signed [COORD_W-1:0] min_imag;
        logic signed [COORD_W-1:0] max_real;
        logic signed [COORD_W-1:0] max_imag;
        logic [ITER_W-1:0]         max_iterations;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cr;
        logic signed [COORD_W-1:0] ci;
    } point_t;

    // Clamp a wide signed value to the 32 bit signed range.
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [64:0] x);
        logic signed [64:0] hi;
        logic signed [64:0] lo;
        hi = 65'sd2147483647;
        lo = -65'sd2147483648;
        if (x > hi)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (x < lo)
        begin
            return 32'sh8000_0000;
        end
        return x[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/met_front.sv]
`default_nettype none

module met_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire met_pkg::cfg_t              cfg,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [met_pkg::INDEX_W-1:0] real_index,
    input  wire logic [met_pkg::INDEX_W-1:0] imag_index,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output met_pkg::point_t                 out_point
);
    import met_pkg::*;

    localparam int PROD_W = COORD_W + 1 + INDEX_W + 1;

    logic   valid_reg;
    logic   valid_next;
    point_t point_reg;
    point_t point_next;

    // lo + floor((hi - lo) * index / GRID_SIZE), saturated.
    function automatic logic signed [COORD_W-1:0] map_axis(
        input logic signed [COORD_W-1:0] lo,
        input logic signed [COORD_W-1:0] hi,
        input logic [INDEX_W-1:0]        idx
    );
        logic signed [COORD_W:0]   diff;
        logic signed [INDEX_W:0]   idx_s;
        logic signed [PROD_W-1:0]  prod;
        logic signed [PROD_W-1:0]  scaled;
        logic signed [64:0]        sum;
        diff   = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
        idx_s  = {1'b0, idx};
        prod   = diff * idx_s;
        scaled = prod >>> GRID_SHIFT;
        sum    = {{(65-COORD_W){lo[COORD_W-1]}}, lo}
               + {{(65-PROD_W){scaled[PROD_W-1]}}, scaled};
        return sat32(sum);
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_point = point_reg;

    always_comb
    begin
        valid_next = valid_reg;
        point_next = point_reg;
        if (in_valid && in_ready)
        begin
            valid_next    = 1'b1;
            point_next.cr = map_axis(cfg.min_real, cfg.max_real, real_index);
            point_next.ci = map_axis(cfg.min_imag, cfg.max_imag, imag_index);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
    end

endmodule

`default_nettype wire

[rtl/core/met_queue.sv]
`default_nettype none

module met_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire met_pkg::point_t push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output met_pkg::point_t      pop_data
);
    import met_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    point_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/met_back.sv]
`default_nettype none

module met_back #(
    parameter int FRACTION_BITS = met_pkg::FRACTION_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [met_pkg::ITER_W-1:0] max_iterations,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire met_pkg::point_t            in_point,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [met_pkg::ITER_W-1:0]      iteration_count,
    output logic                            reached_limit
);
    import met_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // |z|^2 is held with twice the fraction bits; 4.0 sits at bit 2F+2.
    localparam int          ESC_SHIFT = 2 * FRACTION_BITS + 2;
    localparam bit          ESC_ON    = (ESC_SHIFT <= 63);
    localparam logic [63:0] ESC_LIMIT = ESC_ON ? (64'd1 << (ESC_ON ? ESC_SHIFT : 0)) : 64'd0;

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic signed [COORD_W-1:0] cr_reg;
    logic signed [COORD_W-1:0] cr_next;
    logic signed [COORD_W-1:0] ci_reg;
    logic signed [COORD_W-1:0] ci_next;
    logic signed [COORD_W-1:0] zr_reg;
    logic signed [COORD_W-1:0] zr_next;
    logic signed [COORD_W-1:0] zi_reg;
    logic signed [COORD_W-1:0] zi_next;
    logic [ITER_W-1:0]         count_reg;
    logic [ITER_W-1:0]         count_next;
    logic signed [63:0]        prr_reg;
    logic signed [63:0]        pii_reg;
    logic signed [63:0]        pri_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [ITER_W-1:0]         out_count_reg;
    logic [ITER_W-1:0]         out_count_next;
    logic                      out_limit_reg;
    logic                      out_limit_next;

    logic [63:0]               mag2;
    logic                      escaped;
    logic                      finish;
    logic signed [63:0]        sq;
    logic signed [63:0]        sq_sh;
    logic signed [63:0]        cross_sh;
    logic signed [64:0]        nr_wide;
    logic signed [64:0]        ni_wide;

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign iteration_count = out_count_reg;
    assign reached_limit   = out_limit_reg;

    // Both squares are non-negative and at most 2^62, so the sum fits 64 bits unsigned.
    assign mag2     = $unsigned(prr_reg) + $unsigned(pii_reg);
    assign escaped  = ESC_ON && (mag2 >= ESC_LIMIT);
    assign finish   = (count_reg >= max_iterations) || escaped;
    assign sq       = prr_reg - pii_reg;
    assign sq_sh    = sq >>> FRACTION_BITS;
    assign cross_sh = pri_reg >>> (FRACTION_BITS - 1);
    assign nr_wide  = {sq_sh[63], sq_sh} + {{(65-COORD_W){cr_reg[COORD_W-1]}}, cr_reg};
    assign ni_wide  = {cross_sh[63], cross_sh} + {{(65-COORD_W){ci_reg[COORD_W-1]}}, ci_reg};

    always_comb
    begin
        state_next     = state_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_limit_next = out_limit_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cr_next    = in_point.cr;
                    ci_next    = in_point.ci;
                    zr_next    = in_point.cr;
                    zi_next    = in_point.ci;
                    count_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (finish)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    zr_next    = sat32(nr_wide);
                    zi_next    = sat32(ni_wide);
                    count_next = ITER_W'(count_reg + 1'b1);
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_limit_next = (count_reg == max_iterations);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The three products are taken from z every cycle and used in the update state.
    always_ff @(posedge clk)
    begin
        cr_reg        <= cr_next;
        ci_reg        <= ci_next;
        zr_reg        <= zr_next;
        zi_reg        <= zi_next;
        count_reg     <= count_next;
        out_count_reg <= out_count_next;
        out_limit_reg <= out_limit_next;
        prr_reg       <= zr_reg * zr_reg;
        pii_reg       <= zi_reg * zi_reg;
        pri_reg       <= zr_reg * zi_reg;
    end

endmodule

`default_nettype wire

[rtl/core/mandelbrot_escape_time_unit.sv]
// Channel  Direction  Word layout (lowest bit first)
// s_*      in         tdata: real_index[8:0], imag_index[17:9], zero pad [23:18]
// m_*      out        tdata: iteration_count[15:0]; tuser: reached_limit[0]
// cfg_*    in         cfg_index: register index; cfg_data: value (low 16 bits for the limit)
//
// A pixel is mapped into a register, waits in the queue, then loops through the multiply and update
// states of the iteration engine, which shares one set of three 32x32 multipliers between passes.
// The engine takes a new pixel only in its idle state, once its last result has gone to the result register.
// A two-word queue between mapping and iteration lets new pixels be taken while one iterates.
// Reset is asynchronous and clears control state only; no clearing pass is needed.
// The result register holds a word while m_tready is low; the engine waits behind it.
`default_nettype none

module mandelbrot_escape_time_unit #(
    parameter int FRACTION_BITS = met_pkg::FRACTION_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // real_index[8:0], imag_index[17:9], zeros[23:18]
    input  wire logic [met_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // iteration_count[15:0]
    output logic [met_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // reached_limit[0]
    output logic [met_pkg::OUT_TUSER_W-1:0]      m_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [met_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [met_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import met_pkg::*;

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic              front_valid;
    logic              front_ready;
    point_t            front_point;
    logic              queue_valid;
    logic              queue_ready;
    point_t            queue_point;
    logic [ITER_W-1:0] result_count;
    logic              result_limit;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MIN_REAL:       cfg_next.min_real       = cfg_data;
                CFG_MIN_IMAG:       cfg_next.min_imag       = cfg_data;
                CFG_MAX_REAL:       cfg_next.max_real       = cfg_data;
                CFG_MAX_IMAG:       cfg_next.max_imag       = cfg_data;
                CFG_MAX_ITERATIONS: cfg_next.max_iterations = cfg_data[ITER_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_real       <= RESET_MIN_REAL;
            cfg_reg.min_imag       <= RESET_MIN_IMAG;
            cfg_reg.max_real       <= RESET_MAX_REAL;
            cfg_reg.max_imag       <= RESET_MAX_IMAG;
            cfg_reg.max_iterations <= RESET_MAX_ITER;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    met_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .real_index (s_tdata[INDEX_W-1:0]),
        .imag_index (s_tdata[2*INDEX_W-1:INDEX_W]),
        .out_valid  (front_valid),
        .out_ready  (front_ready),
        .out_point  (front_point)
    );

    met_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_point),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_point)
    );

    met_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .max_iterations  (cfg_reg.max_iterations),
        .in_valid        (queue_valid),
        .in_ready        (queue_ready),
        .in_point        (queue_point),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .iteration_count (result_count),
        .reached_limit   (result_limit)
    );

    assign m_tdata    = result_count;
    assign m_tuser[0] = result_limit;

endmodule

`default_nettype wire

[rtl/core/met_checker.sv]
`default_nettype none

`include "mandelbrot_escape_time_unit_assert.svh"

module met_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [met_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic [met_pkg::OUT_TUSER_W-1:0] m_tuser,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [met_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [met_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import met_pkg::*;

    logic [ITER_W-1:0] lim_reg;
    logic [3:0]        pending_reg;
    logic              in_word;
    logic              out_word;
    logic              out_stall;

    assign in_word   = s_tvalid && s_tready;
    assign out_word  = m_tvalid && m_tready;
    assign out_stall = m_tvalid && !m_tready;

    // Shadow copy of the limit register and of the words still inside the block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg     <= RESET_MAX_ITER;
            pending_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && (cfg_index == CFG_MAX_ITERATIONS))
            begin
                lim_reg <= cfg_data[ITER_W-1:0];
            end
            if (in_word && !out_word)
            begin
                pending_reg <= 4'(pending_reg + 1'b1);
            end
            else if (out_word && !in_word)
            begin
                pending_reg <= 4'(pending_reg - 1'b1);
            end
        end
    end

    `MET_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `MET_ASSERT_SAME(a_limit_flag, m_tvalid, m_tuser[0] == (m_tdata == lim_reg))
    `MET_ASSERT_SAME(a_count_bound, m_tvalid, m_tdata <= lim_reg)
    `MET_ASSERT_SAME(a_no_extra_word, out_word, pending_reg != 4'd0)

endmodule

bind mandelbrot_escape_time_unit met_checker u_met_checker (.*);

`default_nettype wire

[test/mandelbrot_escape_time_checker.sv]
`timescale 1ns / 1ps

module mandelbrot_escape_time_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // real_index[8:0], imag_index[17:9], zeros[23:18]
    input  logic [met_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // iteration_count[15:0]
    input  logic [met_pkg::OUT_TDATA_W-1:0] m_tdata,
    // reached_limit[0]
    input  logic [met_pkg::OUT_TUSER_W-1:0] m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [met_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [met_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatch_count,
    output int                              pending_results
);

    import met_pkg::*;

    typedef struct packed {
        logic [ITER_W-1:0] iterations;
        logic              at_limit;
    } escape_result_t;

    localparam int WIDE_W = 66;
    localparam logic signed [WIDE_W-1:0] COORD_MAX = 66'sd2147483647;
    localparam logic signed [WIDE_W-1:0] COORD_MIN = -66'sd2147483648;
    // The escape test compares |z|^2 against 4 at twice the fraction width.
    localparam logic signed [WIDE_W-1:0] ESCAPE_BOUND = 66'sd1 <<< (2 * FRACTION_BITS + 2);

    logic signed [COORD_W-1:0] window_min_re;
    logic signed [COORD_W-1:0] window_min_im;
    logic signed [COORD_W-1:0] window_max_re;
    logic signed [COORD_W-1:0] window_max_im;
    logic [ITER_W-1:0]         iteration_limit;
    escape_result_t            results_due [$];
    escape_result_t            oldest;

    function automatic logic signed [WIDE_W-1:0] saturate_coord(
        input logic signed [WIDE_W-1:0] x);
        if (x > COORD_MAX)
        begin
            return COORD_MAX;
        end
        if (x < COORD_MIN)
        begin
            return COORD_MIN;
        end
        return x;
    endfunction

    // Pixel index to plane coordinate; the shift floors, so inverted corners round down too.
    function automatic logic signed [WIDE_W-1:0] axis_point(
        input logic signed [COORD_W-1:0] lo,
        input logic signed [COORD_W-1:0] hi,
        input logic [INDEX_W-1:0]        idx);
        logic signed [WIDE_W-1:0] lo_w;
        logic signed [WIDE_W-1:0] span;
        logic signed [WIDE_W-1:0] scaled;
        lo_w = lo;
        span = hi;
        span = span - lo_w;
        scaled = (span * $signed({{(WIDE_W - INDEX_W){1'b0}}, idx})) >>> GRID_SHIFT;
        return saturate_coord(lo_w + scaled);
    endfunction

    function automatic escape_result_t escape_count(
        input logic [INDEX_W-1:0] re_idx,
        input logic [INDEX_W-1:0] im_idx);
        logic signed [WIDE_W-1:0] cr;
        logic signed [WIDE_W-1:0] ci;
        logic signed [WIDE_W-1:0] zr;
        logic signed [WIDE_W-1:0] zi;
        logic signed [WIDE_W-1:0] square_diff;
        logic signed [WIDE_W-1:0] product_ri;
        int unsigned              passes;
        escape_result_t           r;
        cr = axis_point(window_min_re, window_max_re, re_idx);
        ci = axis_point(window_min_im, window_max_im, im_idx);
        zr = cr;
        zi = ci;
        passes = 0;
        while (passes < iteration_limit && zr * zr + zi * zi < ESCAPE_BOUND)
        begin
            square_diff = zr * zr - zi * zi;
            product_ri = zr * zi;
            zr = saturate_coord((square_diff >>> FRACTION_BITS) + cr);
            zi = saturate_coord((product_ri >>> (FRACTION_BITS - 1)) + ci);
            passes++;
        end
        r.iterations = ITER_W'(passes);
        r.at_limit = (passes == iteration_limit);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_min_re <= RESET_MIN_REAL;
            window_min_im <= RESET_MIN_IMAG;
            window_max_re <= RESET_MAX_REAL;
            window_max_im <= RESET_MAX_IMAG;
            iteration_limit <= RESET_MAX_ITER;
            results_due.delete();
            pending_results <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MIN_REAL:       window_min_re <= cfg_data;
                    CFG_MIN_IMAG:       window_min_im <= cfg_data;
                    CFG_MAX_REAL:       window_max_re <= cfg_data;
                    CFG_MAX_IMAG:       window_max_im <= cfg_data;
                    CFG_MAX_ITERATIONS: iteration_limit <= cfg_data[ITER_W-1:0];
                    default:            ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                results_due.insert(results_due.size(),
                                   escape_count(s_tdata[INDEX_W-1:0],
                                                s_tdata[2*INDEX_W-1:INDEX_W]));
            end
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("%0t: result word with nothing due: count %0d, limit flag %0b",
                                 $time, m_tdata, m_tuser[0]);
                    end
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    oldest = results_due.pop_front();
                    if (m_tdata !== oldest.iterations || m_tuser[0] !== oldest.at_limit)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("%0t: expected count %0d limit flag %0b, got count %0d %s %0b",
                                     $time, oldest.iterations, oldest.at_limit, m_tdata,
                                     "limit flag", m_tuser[0]);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            pending_results <= results_due.size();
        end
    end

endmodule

[test/mandelbrot_escape_time_unit_test.sv]
`timescale 1ns / 1ps

module mandelbrot_escape_time_unit_test;

    import met_pkg::*;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_THREE_OF_FOUR,
        READY_SPARSE
    } ready_mode_t;

    typedef enum logic [1:0] {
        WINDOW_ANYWHERE,
        WINDOW_WHOLE_SET,
        WINDOW_INVERTED,
        WINDOW_CLOSEUP
    } window_kind_t;

    localparam int LONG_HOLD = 2500;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     mismatch_count;
    int                     pending_results;

    logic                   hold_results = 1'b0;
    logic                   sender_gaps = 1'b1;
    int                     burst_left = 0;
    ready_mode_t            ready_mode = READY_ALWAYS;
    int                     mode_left = 0;
    int                     stall_left = 0;
    logic [1:0]             ready_tick = '0;

    always #4 clk = ~clk;

    mandelbrot_escape_time_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mandelbrot_escape_time_checker checker_inst
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Result side: a stall pattern redrawn at random from four modes, plus one long
    // hold-off on request so that the pixel queue backs up into the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left <= 0;
            mode_left <= 0;
        end
        else if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (hold_results)
        begin
            m_tready <= 1'b0;
            stall_left <= LONG_HOLD;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode <= ready_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(20, 400);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            ready_tick <= ready_tick + 1'b1;
            case (ready_mode)
                READY_ALWAYS:        m_tready <= 1'b1;
                READY_COIN:          m_tready <= 1'($urandom_range(0, 1));
                READY_THREE_OF_FOUR: m_tready <= (ready_tick != 2'd0);
                READY_SPARSE:        m_tready <= ($urandom_range(0, 7) == 0);
                default:             m_tready <= 1'b1;
            endcase
        end
    end

    function automatic logic [INDEX_W-1:0] pick_index();
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom_range(0, 1) ? {INDEX_W{1'b1}} : '0;
        end
        return INDEX_W'($urandom_range(0, GRID_SIZE - 1));
    endfunction

    function automatic cfg_t random_window();
        cfg_t                      w;
        window_kind_t              kind;
        logic signed [COORD_W-1:0] swap;
        kind = window_kind_t'($urandom_range(0, 3));
        case (kind)
            WINDOW_ANYWHERE:
            begin
                w.min_real = $urandom;
                w.min_imag = $urandom;
                w.max_real = $urandom;
                w.max_imag = $urandom;
            end
            WINDOW_CLOSEUP:
            begin
                // A narrow window near the edge of the set gives a spread of counts.
                w.min_real = -201326592 + int'($urandom_range(0, 1 << 26));
                w.min_imag = 26843545 + int'($urandom_range(0, 1 << 26));
                w.max_real = w.min_real + int'($urandom_range(0, 1 << 22));
                w.max_imag = w.min_imag + int'($urandom_range(0, 1 << 22));
            end
            default:
            begin
                w.min_real = -671088640 + int'($urandom_range(0, 536870912));
                w.min_imag = -402653184 + int'($urandom_range(0, 402653184));
                w.max_real = w.min_real + int'($urandom_range(1 << 16, 805306368));
                w.max_imag = w.min_imag + int'($urandom_range(1 << 16, 805306368));
                if (kind == WINDOW_INVERTED)
                begin
                    swap = w.min_real;
                    w.min_real = w.max_real;
                    w.max_real = swap;
                    swap = w.min_imag;
                    w.min_imag = w.max_imag;
                    w.max_imag = swap;
                end
            end
        endcase
        if ($urandom_range(0, 9) < 7)
        begin
            w.max_iterations = ITER_W'($urandom_range(1, 64));
        end
        else
        begin
            w.max_iterations = ITER_W'($urandom_range(65, 400));
        end
        return w;
    endfunction

    // Leaves cfg_valid high so that back-to-back writes need no second assignment per step.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apply_window(input cfg_t w);
        write_register(CFG_MIN_REAL, w.min_real);
        write_register(CFG_MIN_IMAG, w.min_imag);
        write_register(CFG_MAX_REAL, w.max_real);
        write_register(CFG_MAX_IMAG, w.max_imag);
        write_register(CFG_MAX_ITERATIONS, {{(CFG_DATA_W - ITER_W){1'b0}}, w.max_iterations});
        cfg_valid <= 1'b0;
    endtask

    task automatic offer_pixel(input logic [INDEX_W-1:0] re_idx,
                               input logic [INDEX_W-1:0] im_idx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (sender_gaps && gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tdata <= {{(IN_TDATA_W - 2 * INDEX_W){1'b0}}, im_idx, re_idx};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_results != 0);
    endtask

    initial
    begin
        cfg_t window;
        cfg_t reset_window;
        reset_window.min_real = RESET_MIN_REAL;
        reset_window.min_imag = RESET_MIN_IMAG;
        reset_window.max_real = RESET_MAX_REAL;
        reset_window.max_imag = RESET_MAX_IMAG;
        reset_window.max_iterations = RESET_MAX_ITER;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window: three grid corners are already outside, a pixel near the origin runs to the limit.
        offer_pixel(9'd0, 9'd0);
        offer_pixel(9'd511, 9'd511);
        offer_pixel(9'd0, 9'd511);
        offer_pixel(9'd511, 9'd0);
        offer_pixel(9'd341, 9'd205);
        offer_pixel(9'd171, 9'd300);
        drain_results();

        // Limit of one.
        window = reset_window;
        window.max_iterations = 16'd1;
        apply_window(window);
        offer_pixel(9'd341, 9'd205);
        offer_pixel(9'd0, 9'd0);
        offer_pixel(9'd511, 9'd255);
        drain_results();

        // Largest limit on a window collapsed to the origin: one full-length pixel.
        window = '0;
        window.max_iterations = 16'hFFFF;
        apply_window(window);
        offer_pixel(9'd73, 9'd400);
        drain_results();

        // Full coordinate range, imaginary axis inverted.
        window.min_real = 32'sh8000_0000;
        window.max_real = 32'sh7FFF_FFFF;
        window.min_imag = 32'sh7FFF_FFFF;
        window.max_imag = 32'sh8000_0000;
        window.max_iterations = 16'hFFFF;
        apply_window(window);
        offer_pixel(9'd0, 9'd0);
        offer_pixel(9'd511, 9'd511);
        offer_pixel(9'd256, 9'd0);
        offer_pixel(9'd0, 9'd256);
        drain_results();

        // Back-pressure: results are held off while pixels keep coming.
        window = reset_window;
        window.max_iterations = 16'd8;
        apply_window(window);
        sender_gaps = 1'b0;
        hold_results <= 1'b1;
        @(posedge clk);
        hold_results <= 1'b0;
        repeat (12) offer_pixel(pick_index(), pick_index());
        drain_results();

        for (int phase = 0; phase < 14; phase++)
        begin
            window = random_window();
            if (phase == 5)
            begin
                window = reset_window;
            end
            apply_window(window);
            sender_gaps = (phase % 3 != 0);
            repeat (20) offer_pixel(pick_index(), pick_index());
            drain_results();
        end

        repeat (64) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[mandelbrot_escape_time_unit.f]
+incdir+rtl/core
rtl/core/met_pkg.sv
rtl/core/met_front.sv
rtl/core/met_queue.sv
rtl/core/met_back.sv
rtl/core/mandelbrot_escape_time_unit.sv
rtl/core/met_checker.sv
test/mandelbrot_escape_time_checker.sv
test/mandelbrot_escape_time_unit_test.sv
